// ----- rtl/core/split_phase_barrier_unit_assert.svh -----
// Assertion macros for the split-phase barrier unit.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef SPLIT_PHASE_BARRIER_UNIT_ASSERT_SVH
`define SPLIT_PHASE_BARRIER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPBU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPBU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/spbu_pkg.sv -----
package spbu_pkg;

    localparam int MAX_THREADS = 64;

    localparam int TID_W = 6;
    localparam int ID_W  = 32;
    localparam int CNT_W = 7;

    localparam logic [ID_W-1:0] WILDCARD_ID = 32'h8000_0000;

    localparam logic KIND_NOTIFY = 1'b0;
    localparam logic KIND_WAIT   = 1'b1;

    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_NOTIFY_TWICE   = 2'd1;
    localparam logic [1:0] ST_WAIT_NO_NOTIFY = 2'd2;
    localparam logic [1:0] ST_MISMATCH       = 2'd3;

    localparam logic [1:0] STEP_OWN    = 2'd0;
    localparam logic [1:0] STEP_CHILD1 = 2'd1;
    localparam logic [1:0] STEP_CHILD2 = 2'd2;
    localparam logic [1:0] STEP_PARENT = 2'd3;

    function automatic logic ids_match(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
        return (a == WILDCARD_ID) || (b == WILDCARD_ID) || (a == b);
    endfunction

endpackage

// ----- rtl/core/split_phase_barrier_unit.sv -----
// A notify, an ignored event or a wait rejected by its flags goes from S_EVAL to S_DONE before
// m_valid is raised; a wait that reaches the id checks first runs four read-and-compare rounds
// (S_READ, S_CHECK) through the single id comparator and the shared read address. One event at
// a time: s_ready is high only in S_IDLE, and S_DONE holds while a result still waits for m_ready.
// Reset (aresetn, synchronous, active low) clears all flags and the arrival count and sets
// the thread count to 64; the id memories are not cleared.
`include "split_phase_barrier_unit_assert.svh"

module split_phase_barrier_unit
    import spbu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CNT_W-1:0]        cfg_thread_count,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_kind,
    input  logic [TID_W-1:0]        s_thread,
    input  logic signed [ID_W-1:0]  s_barrier_id,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic                    m_released
);

    localparam int AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       thread_count_reg;
    logic [MAX_THREADS-1:0] active_flags_reg;
    logic [MAX_THREADS-1:0] arrived_flags_reg;
    logic [CNT_W-1:0]       arrived_count_reg;

    logic                   kind_reg;
    logic [TID_W-1:0]       thread_reg;
    logic [ID_W-1:0]        id_reg;
    logic [1:0]             step_reg;
    logic [1:0]             status_reg;
    logic                   commit_reg;

    logic                   m_valid_reg;
    logic [1:0]             m_status_reg;
    logic                   m_released_reg;

    logic [ID_W-1:0]        notify_mem [MAX_THREADS];
    logic [ID_W-1:0]        wait_mem   [MAX_THREADS];
    logic [ID_W-1:0]        rd_notify_reg;
    logic [ID_W-1:0]        rd_wait_reg;

    logic [CNT_W-1:0]       eff_count;
    logic [CNT_W:0]         child1;
    logic [CNT_W:0]         child2;
    logic [TID_W-2:0]       parent;
    logic [TID_W-1:0]       thread_dec;
    logic [AW-1:0]          own_addr;
    logic [AW-1:0]          rd_addr;
    logic                   step_en;
    logic                   cmp_match;
    logic                   out_free;
    logic [CNT_W:0]         count_next;
    logic                   release_now;
    logic                   mem_we;

    // A count of zero behaves as one; counts beyond the thread capacity are clamped.
    always_comb begin
        if (thread_count_reg == '0) begin
            eff_count = CNT_W'(1);
        end else if (32'(thread_count_reg) > MAX_THREADS) begin
            eff_count = CNT_W'(MAX_THREADS);
        end else begin
            eff_count = thread_count_reg;
        end
    end

    assign thread_dec = thread_reg - TID_W'(1);
    assign parent     = thread_dec[TID_W-1:1];
    assign child1     = {2'b00, thread_reg} + {1'b0, thread_reg} + (CNT_W+1)'(1);
    assign child2     = {2'b00, thread_reg} + {1'b0, thread_reg} + (CNT_W+1)'(2);
    assign own_addr   = AW'(thread_reg);

    always_comb begin
        case (step_reg)
            STEP_OWN: begin
                rd_addr = own_addr;
                step_en = 1'b1;
            end
            STEP_CHILD1: begin
                rd_addr = AW'(child1);
                step_en = (child1 < {1'b0, eff_count}) && arrived_flags_reg[AW'(child1)];
            end
            STEP_CHILD2: begin
                rd_addr = AW'(child2);
                step_en = (child2 < {1'b0, eff_count}) && arrived_flags_reg[AW'(child2)];
            end
            STEP_PARENT: begin
                rd_addr = AW'(parent);
                step_en = (thread_reg != '0) && arrived_flags_reg[AW'(parent)];
            end
            default: begin
                rd_addr = own_addr;
                step_en = 1'b0;
            end
        endcase
    end

    // The one id comparator, shared by all four checks of a wait.
    assign cmp_match = ids_match(id_reg, (step_reg == STEP_PARENT) ? rd_wait_reg : rd_notify_reg);

    assign out_free    = !m_valid_reg || m_ready;
    assign count_next  = {1'b0, arrived_count_reg} + (CNT_W+1)'(1);
    assign release_now = (kind_reg == KIND_WAIT) && commit_reg
                         && (count_next >= {1'b0, eff_count});
    assign mem_we      = (state_reg == S_DONE) && out_free && commit_reg;

    always_ff @(posedge aclk) begin
        if (mem_we && (kind_reg == KIND_NOTIFY)) begin
            notify_mem[own_addr] <= id_reg;
        end
        if (state_reg == S_READ) begin
            rd_notify_reg <= notify_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we && (kind_reg == KIND_WAIT)) begin
            wait_mem[own_addr] <= id_reg;
        end
        if (state_reg == S_READ) begin
            rd_wait_reg <= wait_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            thread_count_reg  <= CNT_W'(64);
            active_flags_reg  <= '0;
            arrived_flags_reg <= '0;
            arrived_count_reg <= '0;
            m_valid_reg       <= 1'b0;
            step_reg          <= STEP_OWN;
            commit_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                thread_count_reg <= cfg_thread_count;
            end
            // In S_DONE the result register is reloaded below instead.
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        kind_reg   <= s_kind;
                        thread_reg <= s_thread;
                        id_reg     <= s_barrier_id;
                        state_reg  <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    step_reg <= STEP_OWN;
                    if ({1'b0, thread_reg} >= eff_count) begin
                        // Threads outside the barrier are ignored.
                        status_reg <= ST_OK;
                        commit_reg <= 1'b0;
                        state_reg  <= S_DONE;
                    end else if (kind_reg == KIND_NOTIFY) begin
                        status_reg <= active_flags_reg[own_addr] ? ST_NOTIFY_TWICE : ST_OK;
                        commit_reg <= !active_flags_reg[own_addr];
                        state_reg  <= S_DONE;
                    end else if (!active_flags_reg[own_addr] || arrived_flags_reg[own_addr]) begin
                        status_reg <= ST_WAIT_NO_NOTIFY;
                        commit_reg <= 1'b0;
                        state_reg  <= S_DONE;
                    end else begin
                        status_reg <= ST_OK;
                        commit_reg <= 1'b1;
                        state_reg  <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (step_en && !cmp_match) begin
                        status_reg <= ST_MISMATCH;
                        commit_reg <= 1'b0;
                    end
                    if (step_reg == STEP_PARENT) begin
                        state_reg <= S_DONE;
                    end else begin
                        step_reg  <= step_reg + 2'd1;
                        state_reg <= S_READ;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_status_reg   <= status_reg;
                        m_released_reg <= release_now;
                        state_reg      <= S_IDLE;
                        if (commit_reg) begin
                            if (kind_reg == KIND_NOTIFY) begin
                                active_flags_reg[own_addr] <= 1'b1;
                            end else if (release_now) begin
                                active_flags_reg  <= '0;
                                arrived_flags_reg <= '0;
                                arrived_count_reg <= '0;
                            end else begin
                                arrived_flags_reg[own_addr] <= 1'b1;
                                arrived_count_reg           <= count_next[CNT_W-1:0];
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_released = m_released_reg;

    `SPBU_ASSERT_SAME(a_arrived_implies_active, 1'b1,
        (arrived_flags_reg & ~active_flags_reg) == '0, "arrived thread without notify")
    `SPBU_ASSERT_SAME(a_count_matches_flags, 1'b1,
        $countones(arrived_flags_reg) == int'(arrived_count_reg), "arrival count out of step")
    `SPBU_ASSERT_SAME(a_release_only_ok, m_valid_reg && m_released_reg,
        m_status_reg == ST_OK, "release reported with an error status")
    `SPBU_ASSERT_NEXT(a_busy_after_transfer, s_valid && s_ready,
        !s_ready, "input taken while an event is in progress")

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import spbu_pkg::*;

    localparam int RANDOM_EVENTS = 1000;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 30;

    typedef struct packed {
        logic [1:0] status;
        logic       released;
    } outcome_t;

    // Tracks the barrier state as the unit should see it and queues the
    // outcome due for every event transfer.
    class barrier_scoreboard;
        logic [CNT_W-1:0] thread_count;
        bit               active [MAX_THREADS];
        bit               arrived [MAX_THREADS];
        logic [ID_W-1:0]  notify_id [MAX_THREADS];
        logic [ID_W-1:0]  wait_id [MAX_THREADS];
        int unsigned      arrivals;
        outcome_t         outcomes_due [$];
        int unsigned      failures;

        function new();
            thread_count = 7'd64;
            arrivals = 0;
            failures = 0;
            foreach (active[i]) begin
                active[i] = 1'b0;
                arrived[i] = 1'b0;
                notify_id[i] = '0;
                wait_id[i] = '0;
            end
        endfunction

        function int unsigned live_threads();
            if (thread_count == 0)
                return 1;
            if (thread_count > MAX_THREADS)
                return MAX_THREADS;
            return 32'(thread_count);
        endfunction

        function bit ids_agree(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
            return (a == WILDCARD_ID) || (b == WILDCARD_ID) || (a == b);
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10)
                $display("barrier mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void note_event(logic kind, logic [TID_W-1:0] thread,
                                 logic [ID_W-1:0] id);
            int unsigned n;
            int unsigned t;
            int unsigned c;
            int unsigned p;
            outcome_t    res;
            n = live_threads();
            t = 32'(thread);
            res.status = ST_OK;
            res.released = 1'b0;
            // Events from threads outside the barrier are answered but leave no trace.
            if (t < n) begin
                if (kind == KIND_NOTIFY) begin
                    if (active[t]) begin
                        res.status = ST_NOTIFY_TWICE;
                    end else begin
                        active[t] = 1'b1;
                        notify_id[t] = id;
                    end
                end else if (!active[t] || arrived[t]) begin
                    res.status = ST_WAIT_NO_NOTIFY;
                end else begin
                    if (!ids_agree(id, notify_id[t]))
                        res.status = ST_MISMATCH;
                    for (c = 2 * t + 1; c <= 2 * t + 2; c++) begin
                        if (c < n && arrived[c] && !ids_agree(id, notify_id[c]))
                            res.status = ST_MISMATCH;
                    end
                    if (t > 0) begin
                        p = (t - 1) / 2;
                        if (arrived[p] && !ids_agree(id, wait_id[p]))
                            res.status = ST_MISMATCH;
                    end
                    if (res.status == ST_OK) begin
                        arrived[t] = 1'b1;
                        wait_id[t] = id;
                        arrivals++;
                        if (arrivals >= n) begin
                            foreach (active[i]) begin
                                active[i] = 1'b0;
                                arrived[i] = 1'b0;
                            end
                            arrivals = 0;
                            res.released = 1'b1;
                        end
                    end
                end
            end
            outcomes_due.push_back(res);
        endfunction

        function void check_outcome(logic [1:0] status, logic released);
            outcome_t due;
            if (outcomes_due.size() == 0) begin
                report($sformatf("unexpected result, status %0d released %0d",
                                 status, released));
                return;
            end
            due = outcomes_due.pop_front();
            if (status !== due.status)
                report($sformatf("status expected %0d, got %0d", due.status, status));
            if (released !== due.released)
                report($sformatf("released expected %0d, got %0d", due.released, released));
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CNT_W-1:0]       cfg_thread_count = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_kind = KIND_NOTIFY;
    logic [TID_W-1:0]       s_thread = '0;
    logic signed [ID_W-1:0] s_barrier_id = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_status;
    logic                   m_released;

    barrier_scoreboard sb;
    int unsigned       events_sent = 0;
    int                send_calm = 0;
    int                stall_left = 0;
    int                recv_calm = 0;

    split_phase_barrier_unit uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_thread_count(cfg_thread_count),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_thread(s_thread),
        .s_barrier_id(s_barrier_id),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_released(m_released)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic send_event(logic kind, logic [TID_W-1:0] thread, logic [ID_W-1:0] id);
        int gap;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            gap = pause_length();
            if ($urandom_range(0, 39) == 0)
                send_calm = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_thread <= thread;
        s_barrier_id <= id;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_event(kind, thread, id);
        events_sent++;
    endtask

    // The count is only changed once every outstanding result has been taken.
    task automatic write_count(logic [CNT_W-1:0] value);
        s_valid <= 1'b0;
        while (sb.outcomes_due.size() != 0)
            @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_thread_count <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.thread_count = value;
    endtask

    // Brings the barrier back to a clean start by completing the current phase
    // with wildcard waits, which can never mismatch.
    task automatic settle_phase();
        int unsigned n;
        bit          stuck;
        n = sb.live_threads();
        stuck = 1'b1;
        for (int t = 0; t < n; t++) begin
            if (!sb.arrived[t])
                stuck = 1'b0;
        end
        // After the count has been lowered, every member may already have
        // arrived with no way left to release; widen the barrier again.
        if (stuck) begin
            write_count(CNT_W'(MAX_THREADS));
            n = MAX_THREADS;
        end
        for (int t = 0; t < n; t++) begin
            if (!sb.active[t])
                send_event(KIND_NOTIFY, TID_W'(t),
                           $urandom_range(0, 1) ? WILDCARD_ID : $urandom);
        end
        for (int t = 0; t < n; t++) begin
            if (sb.active[t] && !sb.arrived[t])
                send_event(KIND_WAIT, TID_W'(t), WILDCARD_ID);
        end
    endtask

    // One barrier phase: every member notifies and then waits, in random
    // interleaving, with occasional stray or faulty events mixed in.
    task automatic run_phase();
        int unsigned     n;
        int unsigned     t;
        int unsigned     left;
        int              r;
        logic [ID_W-1:0] base;
        logic [ID_W-1:0] wid;
        int              stage [MAX_THREADS];
        n = sb.live_threads();
        base = ($urandom_range(0, 19) == 0) ? WILDCARD_ID : $urandom;
        foreach (stage[i])
            stage[i] = 0;
        left = 2 * n;
        while (left > 0) begin
            if ($urandom_range(0, 11) == 0) begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    send_event(1'($urandom_range(0, 1)), TID_W'($urandom_range(0, 63)),
                               $urandom);
                else if (r == 1)
                    send_event(KIND_NOTIFY, TID_W'($urandom_range(0, n - 1)), $urandom);
                else
                    send_event(KIND_WAIT, TID_W'($urandom_range(0, n - 1)),
                               $urandom_range(0, 1) ? base : $urandom);
            end
            do
                t = $urandom_range(0, n - 1);
            while (stage[t] == 2);
            if (stage[t] == 0) begin
                send_event(KIND_NOTIFY, TID_W'(t),
                           ($urandom_range(0, 4) == 0) ? WILDCARD_ID : base);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    wid = base;
                else if (r < 95)
                    wid = WILDCARD_ID;
                else
                    wid = $urandom;
                send_event(KIND_WAIT, TID_W'(t), wid);
            end
            stage[t]++;
            left--;
        end
        settle_phase();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_outcome(m_status, m_released);
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (recv_calm > 0) begin
                recv_calm--;
            end else begin
                stall_left = pause_length();
                if ($urandom_range(0, 49) == 0)
                    recv_calm = $urandom_range(30, 120);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("split_phase_barrier_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned      random_end;
        int               r;
        logic [CNT_W-1:0] count;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Own-id checks on thread 0 with the full barrier of 64.
        send_event(KIND_WAIT, 0, 32'd0);
        send_event(KIND_NOTIFY, 0, 32'h7FFF_FFFF);
        send_event(KIND_NOTIFY, 0, 32'd0);
        send_event(KIND_WAIT, 0, 32'h8000_0001);
        send_event(KIND_WAIT, 0, WILDCARD_ID);
        send_event(KIND_WAIT, 0, WILDCARD_ID);

        // Shrink to three threads with thread 0 already arrived.
        write_count(7'd3);
        send_event(KIND_NOTIFY, 63, 32'hFFFF_FFFF);
        send_event(KIND_NOTIFY, 1, 32'h7FFF_FFFF);
        send_event(KIND_NOTIFY, 2, 32'd5);
        send_event(KIND_WAIT, 2, 32'd5);
        send_event(KIND_WAIT, 1, 32'd0);
        send_event(KIND_WAIT, 1, 32'h7FFF_FFFF);

        // A parent waiting after a child with a different id.
        send_event(KIND_NOTIFY, 0, 32'd10);
        send_event(KIND_NOTIFY, 1, 32'd20);
        send_event(KIND_NOTIFY, 2, WILDCARD_ID);
        send_event(KIND_WAIT, 1, 32'd20);
        send_event(KIND_WAIT, 0, 32'd10);
        send_event(KIND_WAIT, 0, WILDCARD_ID);
        send_event(KIND_WAIT, 2, 32'd99);

        // Child waiting after its parent, then the count lowered mid-phase.
        write_count(7'd4);
        send_event(KIND_NOTIFY, 0, 32'd7);
        send_event(KIND_NOTIFY, 1, WILDCARD_ID);
        send_event(KIND_WAIT, 0, 32'd7);
        write_count(7'd2);
        send_event(KIND_WAIT, 1, 32'd8);
        send_event(KIND_WAIT, 1, 32'd7);

        // Out-of-range counts: zero behaves as one, 127 as the maximum.
        write_count(7'd0);
        send_event(KIND_NOTIFY, 1, 32'd1);
        send_event(KIND_NOTIFY, 0, 32'd1);
        send_event(KIND_WAIT, 0, 32'd1);
        write_count(7'd127);
        send_event(KIND_NOTIFY, 63, 32'd0);
        settle_phase();

        random_end = events_sent + RANDOM_EVENTS;
        while (events_sent < random_end) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                count = 7'd0;
            else if (r < 16)
                count = CNT_W'($urandom_range(65, 127));
            else if (r < 28)
                count = 7'd64;
            else
                count = CNT_W'($urandom_range(1, 12));
            write_count(count);
            repeat ($urandom_range(1, 3)) run_phase();
        end

        s_valid <= 1'b0;
        while (sb.outcomes_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.outcomes_due.size() == 0)
            $display("split_phase_barrier_unit regression: pass");
        else
            $display("split_phase_barrier_unit regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/spbu_pkg.sv
rtl/core/split_phase_barrier_unit.sv
tb/tb_top.sv
